/* hdl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit block allocator
// Grid geometry, field widths, status codes, sequencer states and the
// control bundle to the occupancy store.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Geometry
  localparam int MAX_PAGES = 4;
  localparam int MAX_COLS  = 32;
  localparam int MAX_ROWS  = 32;
  localparam int BLOCK_W   = 16;
  localparam int BLOCK_H   = 16;

  // Widths derived from geometry
  localparam int SZ_W   = 10;
  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PO_W   = $clog2(MAX_PAGES + 1);
  localparam int XW     = $clog2(MAX_COLS);
  localparam int YW     = $clog2(MAX_ROWS);
  localparam int CW_W   = $clog2(MAX_COLS + 1);
  localparam int RW_W   = $clog2(MAX_ROWS + 1);
  localparam int BW_W   = $clog2(((1 << SZ_W) - 1 + BLOCK_W - 1) / BLOCK_W + 1);
  localparam int BH_W   = $clog2(((1 << SZ_W) - 1 + BLOCK_H - 1) / BLOCK_H + 1);
  localparam int ADDR_W = PG_W + YW;
  localparam int DEPTH  = MAX_PAGES * MAX_ROWS;

  // Fixed field widths of the stream items
  localparam int PAGE_F_W = 2;
  localparam int BX_W     = 5;
  localparam int BY_W     = 5;
  localparam int PIX_W    = 9;

  // Register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOC    = 2'd0,
    ST_FREED    = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_NO_SPACE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW,
    S_ACC_RD,
    S_ACC_DAT,
    S_EVAL,
    S_OPEN,
    S_WR_RD,
    S_WR_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [MAX_COLS-1:0] wdata;
    logic [ADDR_W-1:0]   raddr;
    logic                clr;
    logic [PG_W-1:0]     clr_page;
  } mem_ctrl_t;

  // Run of count ones starting at column first
  function automatic logic [MAX_COLS-1:0] span_mask(input logic [XW-1:0] first,
                                                    input logic [BW_W-1:0] count);
    logic [MAX_COLS-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (i >= int'(first) && i < int'(first) + int'(count)) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

/* hdl/ffa_occ_mem.sv */
// ----------------------------------------------------------------------------
// ffa_occ_mem: occupancy row store
// One row of column bits per page row, one write and one registered read a
// cycle. Per-row valid flops make unwritten or cleared rows read as zero.
// ----------------------------------------------------------------------------
module ffa_occ_mem (
  input  logic                             clk,
  input  logic                             rst,
  input  ffa_pkg::mem_ctrl_t               ctrl,
  output logic [ffa_pkg::MAX_COLS-1:0]     rd_row
);
  import ffa_pkg::*;

  logic [MAX_COLS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid;
  logic [MAX_COLS-1:0] q;
  logic                vq;

  // Row array
  always_ff @(posedge clk) begin
    if (ctrl.we) mem[ctrl.waddr] <= ctrl.wdata;
    q <= mem[ctrl.raddr];
  end

  // Row valid bits: cleared by reset and on page open
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vq    <= 1'b0;
    end else begin
      if (ctrl.clr) valid[{ctrl.clr_page, YW'(0)} +: MAX_ROWS] <= '0;
      if (ctrl.we) valid[ctrl.waddr] <= 1'b1;
      vq <= valid[ctrl.raddr];
    end
  end

  assign rd_row = vq ? q : '0;

endmodule

/* hdl/atlas_block_first_fit_allocator.sv */
// ----------------------------------------------------------------------------
// atlas_block_first_fit_allocator: first-fit rectangle allocator
// Free clears the rectangle row by row with read-modify-write; too big goes
// straight to the result; allocate reads bh rows for each row position tried
// up to the first fit through the single read port, opens a page when no open
// page fits, then marks the rectangle row by row.
// One item at a time; the next is taken once the result is in the output
// register. Reset closes all pages and sets a 32 x 32 grid; row valid flops
// clear at once, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module atlas_block_first_fit_allocator (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // req_width, req_height, free_page, free_block_x, free_block_y
  input  logic        s_tuser,   // action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // page_index, block_col, block_row, pixel_x, pixel_y, pad
  output logic [1:0]  m_tuser,   // status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffa_pkg::*;

  // Input fields
  logic [SZ_W-1:0]     in_w, in_h;
  logic [PAGE_F_W-1:0] in_pg;
  logic [BX_W-1:0]     in_fx;
  logic [BY_W-1:0]     in_fy;
  assign in_w  = s_tdata[9:0];
  assign in_h  = s_tdata[19:10];
  assign in_pg = s_tdata[21:20];
  assign in_fx = s_tdata[26:22];
  assign in_fy = s_tdata[31:27];

  state_t              state, state_next;
  logic [CW_W-1:0]     grid_columns;
  logic [RW_W-1:0]     grid_rows;
  logic [PO_W-1:0]     pages_open, pages_open_next;
  logic [BW_W-1:0]     bw, bw_next;
  logic [BH_W-1:0]     bh, bh_next;
  logic [PO_W-1:0]     pg, pg_next;
  logic [RW_W-1:0]     y, y_next;
  logic [RW_W-1:0]     row, row_next;
  logic [RW_W-1:0]     row_end, row_end_next;
  logic [MAX_COLS-1:0] acc, acc_next;
  logic [MAX_COLS-1:0] mask, mask_next;
  logic                set_op, set_op_next;
  status_t             res_st, res_st_next;
  logic [PAGE_F_W-1:0] res_pg, res_pg_next;
  logic [BX_W-1:0]     res_col, res_col_next;
  logic [BY_W-1:0]     res_row, res_row_next;
  logic                out_load;
  mem_ctrl_t           mc;
  logic [MAX_COLS-1:0] rd_row;

  // Configuration port
  function automatic logic [CW_W-1:0] clamp_cols(input logic [31:0] v);
    if (v == '0) return CW_W'(1);
    if (v > 32'(MAX_COLS)) return CW_W'(MAX_COLS);
    return v[CW_W-1:0];
  endfunction

  function automatic logic [RW_W-1:0] clamp_rows(input logic [31:0] v);
    if (v == '0) return RW_W'(1);
    if (v > 32'(MAX_ROWS)) return RW_W'(MAX_ROWS);
    return v[RW_W-1:0];
  endfunction

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= CW_W'(MAX_COLS);
      grid_rows    <= RW_W'(MAX_ROWS);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_COLS) grid_columns <= clamp_cols(pwdata);
      else                      grid_rows    <= clamp_rows(pwdata);
    end
  end

  assign prdata = (paddr[2] == REG_ROWS) ? 32'(grid_rows) : 32'(grid_columns);

  // Request size in blocks
  logic [BW_W-1:0] in_bw;
  logic [BH_W-1:0] in_bh;
  assign in_bw = BW_W'((32'(in_w) + BLOCK_W - 1) / BLOCK_W);
  assign in_bh = BH_W'((32'(in_h) + BLOCK_H - 1) / BLOCK_H);

  // Free clipping
  logic                free_ok;
  logic [CW_W-1:0]     free_room;
  logic [BW_W-1:0]     free_cw;
  logic [BH_W:0]       free_end_full;
  logic [RW_W-1:0]     free_end;
  assign free_ok   = (PO_W'(in_pg) < pages_open) && (CW_W'(in_fx) < grid_columns);
  assign free_room = grid_columns - CW_W'(in_fx);
  assign free_cw   = (in_bw > BW_W'(free_room)) ? BW_W'(free_room) : in_bw;
  assign free_end_full = (BH_W+1)'(in_fy) + (BH_W+1)'(in_bh);
  assign free_end  = (free_end_full > (BH_W+1)'(grid_rows)) ? grid_rows
                                                           : RW_W'(free_end_full);

  // Fit search over one accumulated row band
  logic [MAX_COLS-1:0] cand;
  logic                any_fit;
  logic [XW-1:0]       first_x;
  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      cand[x] = ((BW_W+1)'(x) + (BW_W+1)'(bw) <= (BW_W+1)'(grid_columns)) &&
                ((acc & span_mask(XW'(x), bw)) == '0);
    end
    any_fit = |cand;
    first_x = '0;
    for (int x = MAX_COLS - 1; x >= 0; x--) begin
      if (cand[x]) first_x = XW'(x);
    end
  end

  logic [BH_W:0] y_end_full;
  assign y_end_full = (BH_W+1)'(y) + (BH_W+1)'(bh);

  // Sequencer: next state and datapath
  always_comb begin
    state_next      = state;
    pages_open_next = pages_open;
    bw_next         = bw;
    bh_next         = bh;
    pg_next         = pg;
    y_next          = y;
    row_next        = row;
    row_end_next    = row_end;
    acc_next        = acc;
    mask_next       = mask;
    set_op_next     = set_op;
    res_st_next     = res_st;
    res_pg_next     = res_pg;
    res_col_next    = res_col;
    res_row_next    = res_row;
    out_load        = 1'b0;
    s_tready        = (state == S_IDLE);
    mc              = '0;
    mc.raddr        = {pg[PG_W-1:0], row[YW-1:0]};
    mc.waddr        = {pg[PG_W-1:0], row[YW-1:0]};
    mc.wdata        = set_op ? (rd_row | mask) : (rd_row & ~mask);
    mc.clr_page     = pages_open[PG_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          bw_next = in_bw;
          bh_next = in_bh;
          if (s_tuser) begin
            res_st_next  = ST_FREED;
            res_pg_next  = in_pg;
            res_col_next = in_fx;
            res_row_next = in_fy;
            pg_next      = PO_W'(in_pg);
            row_next     = RW_W'(in_fy);
            row_end_next = free_end;
            mask_next    = span_mask(XW'(in_fx), free_cw);
            set_op_next  = 1'b0;
            if (free_ok && (RW_W'(in_fy) < free_end)) state_next = S_WR_RD;
            else                                      state_next = S_DONE;
          end else if (in_bw > BW_W'(grid_columns) || in_bh > BH_W'(grid_rows)) begin
            res_st_next  = ST_TOO_BIG;
            res_pg_next  = '0;
            res_col_next = '0;
            res_row_next = '0;
            state_next   = S_DONE;
          end else begin
            pg_next    = '0;
            y_next     = '0;
            state_next = (pages_open == '0) ? S_OPEN : S_ROW;
          end
        end
      end

      S_ROW: begin
        acc_next     = '0;
        row_next     = y;
        row_end_next = RW_W'(y_end_full);
        state_next   = (bh == '0) ? S_EVAL : S_ACC_RD;
      end

      S_ACC_RD: state_next = S_ACC_DAT;

      S_ACC_DAT: begin
        acc_next   = acc | rd_row;
        row_next   = row + 1'b1;
        state_next = (row + 1'b1 == row_end) ? S_EVAL : S_ACC_RD;
      end

      S_EVAL: begin
        if (any_fit) begin
          mask_next    = span_mask(first_x, bw);
          set_op_next  = 1'b1;
          res_st_next  = ST_ALLOC;
          res_pg_next  = PAGE_F_W'(pg);
          res_col_next = BX_W'(first_x);
          res_row_next = BY_W'(y);
          row_next     = y;
          row_end_next = RW_W'(y_end_full);
          state_next   = (bh == '0) ? S_DONE : S_WR_RD;
        end else if (y_end_full + 1'b1 <= (BH_W+1)'(grid_rows)) begin
          y_next     = y + 1'b1;
          state_next = S_ROW;
        end else if (pg + 1'b1 < pages_open) begin
          pg_next    = pg + 1'b1;
          y_next     = '0;
          state_next = S_ROW;
        end else begin
          state_next = S_OPEN;
        end
      end

      S_OPEN: begin
        if (pages_open >= PO_W'(MAX_PAGES)) begin
          res_st_next  = ST_NO_SPACE;
          res_pg_next  = '0;
          res_col_next = '0;
          res_row_next = '0;
          state_next   = S_DONE;
        end else begin
          mc.clr          = 1'b1;
          pg_next         = pages_open;
          pages_open_next = pages_open + 1'b1;
          res_st_next     = ST_ALLOC;
          res_pg_next     = PAGE_F_W'(pages_open);
          res_col_next    = '0;
          res_row_next    = '0;
          mask_next       = span_mask('0, bw);
          set_op_next     = 1'b1;
          row_next        = '0;
          row_end_next    = RW_W'(bh);
          state_next      = (bh == '0) ? S_DONE : S_WR_RD;
        end
      end

      S_WR_RD: state_next = S_WR_WR;

      S_WR_WR: begin
        mc.we      = 1'b1;
        row_next   = row + 1'b1;
        state_next = (row + 1'b1 == row_end) ? S_DONE : S_WR_RD;
      end

      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pages_open <= '0;
    end else begin
      state      <= state_next;
      pages_open <= pages_open_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    bw      <= bw_next;
    bh      <= bh_next;
    pg      <= pg_next;
    y       <= y_next;
    row     <= row_next;
    row_end <= row_end_next;
    acc     <= acc_next;
    mask    <= mask_next;
    set_op  <= set_op_next;
    res_st  <= res_st_next;
    res_pg  <= res_pg_next;
    res_col <= res_col_next;
    res_row <= res_row_next;
  end

  // Output register
  logic [PIX_W-1:0] px, py;
  assign px = PIX_W'(32'(res_col) * BLOCK_W);
  assign py = PIX_W'(32'(res_row) * BLOCK_H);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, py, px, res_row, res_col, res_pg};
      m_tuser <= res_st;
    end
  end

  ffa_occ_mem u_occ (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mc),
    .rd_row (rd_row)
  );

  // Checks
  a_pages_bound: assert property (@(posedge clk) disable iff (rst)
    pages_open <= PO_W'(MAX_PAGES))
    else $error("open page count above limit");

  a_pages_step: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || pages_open == $past(pages_open) ||
    pages_open == $past(pages_open) + 1'b1)
    else $error("open page count moved by more than one");

  a_write_in_grid: assert property (@(posedge clk) disable iff (rst)
    mc.we |-> (row < row_end && row_end <= grid_rows))
    else $error("row write outside the grid in use");

  a_open_new_page: assert property (@(posedge clk) disable iff (rst)
    mc.clr |=> (pg == $past(pages_open) && res_st == ST_ALLOC))
    else $error("page open without allocation on it");

endmodule
